// File: src/nsfnv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsfnv_pkg
// Shared types, character codes and helper functions for the name sanitizer.
// ----------------------------------------------------------------------------
package nsfnv_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;
  localparam logic [7:0] CH_NUL        = 8'h00;

  localparam logic [63:0] FALLBACK_NAME = "untitled";

  // Output sequence positions of one item's results
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_CHAR     = 5'd0;
  localparam logic [POS_W-1:0] POS_UNT_0    = 5'd1;
  localparam logic [POS_W-1:0] POS_UNT_LAST = 5'd8;
  localparam logic [POS_W-1:0] POS_SEP      = 5'd9;
  localparam logic [POS_W-1:0] POS_HEX_0    = 5'd10;
  localparam logic [POS_W-1:0] POS_HEX_LAST = 5'd17;
  localparam logic [POS_W-1:0] POS_END      = 5'd18;

  // Work handed from the name state to the output sequencer
  typedef struct packed {
    logic        ch_v;      // one sanitized character to emit
    logic [7:0]  ch;
    logic        tail;      // closing item: end marker follows
    logic        untitled;  // emit the fallback name
    logic        suffix;    // emit '_' and the hash in hex
    logic [31:0] hash;
  } job_t;

  // FNV-1a step; the prime 0x01000193 is bits 24, 8, 7, 4, 1 and 0
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'h0, nib};
    return (nib < 4'd10) ? (CH_DIGIT_0 + n) : (CH_LOWER_A + n - 8'd10);
  endfunction

endpackage : nsfnv_pkg
`default_nettype wire

// File: src/name_sanitizer_with_fnv_suffix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// name_sanitizer_with_fnv_suffix
// Streams a name byte by byte and returns its sanitized form with an optional hash tail.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_tdata carries in_byte, s_tuser carries has_byte and s_tlast
//   marks the closing item of a name (name_end). Master side: m_tdata carries
//   out_char and char_valid, m_tlast marks the end marker of a name.
//   Each byte is folded into a 32-bit FNV-1a hash; letters are lower-cased,
//   digits pass, space/hyphen/underscore collapse to one '_', bytes 0x80 and
//   up are dropped but request a "_xxxxxxxx" hash suffix at the end.
// Path: an accepted item is held in the input register, then loaded into the
//   result register, where m_tvalid goes high; while the sequencer is busy
//   the item waits in the input register.
// Throughput: one item per cycle while each item yields at most one result
//   and m_tready is high; the input register then advances in the same cycle
//   the result is taken. A closing item yields 1 to 18 results (character
//   or fallback name, separator and eight hex digits, end marker), which the
//   single output port walks one result per beat.
// Reset: synchronous, clears the hash to the offset basis and all flags; no
//   clearing pass. Stall: when m_tready is low the result holds, one more
//   item is still taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module name_sanitizer_with_fnv_suffix (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // has_byte
  input  wire logic        s_tlast,   // name_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_char, [8] char_valid, [15:9] zero
  output logic             m_tlast    // out_last
);
  import nsfnv_pkg::*;

  // input register
  logic       item_full;
  logic [7:0] item_byte;
  logic       item_has;
  logic       item_end;

  job_t job;
  logic job_any;
  logic seq_free;
  logic advance;
  logic load;

  // Advance an item whose results can enter the sequencer, or that has none
  assign job_any  = job.ch_v || job.tail;
  assign advance  = item_full && (!job_any || seq_free);
  assign load     = advance && job_any;
  assign s_tready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  // payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_byte <= s_tdata;
      item_has  <= s_tuser;
      item_end  <= s_tlast;
    end
  end

  nsfnv_name_state u_state (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_byte  (item_byte),
    .has_byte (item_has),
    .name_end (item_end),
    .job      (job)
  );

  nsfnv_tail_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .job_in   (job),
    .free     (seq_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // An accepted item always lands in the input register
  a_capture: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> item_full)
    else $error("accepted item not held in input register");

  // Exactly one of character and end marker in every result
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] != m_tlast))
    else $error("result is neither a character nor an end marker");

  // A job is only loaded when the sequencer can take it
  a_load: assert property (@(posedge clk) disable iff (rst)
    load |-> seq_free && (!m_tvalid || m_tready))
    else $error("job loaded over a pending result");

  // A closing item that loads is followed by a result on the next cycle
  a_tail: assert property (@(posedge clk) disable iff (rst)
    load && job.tail |=> m_tvalid)
    else $error("closing item produced no result");
`endif

endmodule : name_sanitizer_with_fnv_suffix
`default_nettype wire

// File: src/nsfnv_name_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsfnv_name_state
// Per-name state: running hash, flags, and classification of one byte.
// ----------------------------------------------------------------------------
module nsfnv_name_state (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [7:0]    in_byte,
  input  wire logic          has_byte,
  input  wire logic          name_end,
  output nsfnv_pkg::job_t    job
);
  import nsfnv_pkg::*;

  logic [31:0] hash_value, hash_value_next;
  logic        saw_high_byte, saw_high_byte_next;
  logic        emitted_any, emitted_any_next;
  logic        prev_was_underscore, prev_was_underscore_next;

  logic       is_lower, is_upper, is_digit, is_sep;
  logic       emit;
  logic [7:0] ch;

  always_comb begin
    is_lower = (in_byte >= CH_LOWER_A) && (in_byte <= CH_LOWER_Z);
    is_upper = (in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z);
    is_digit = (in_byte >= CH_DIGIT_0) && (in_byte <= CH_DIGIT_9);
    is_sep   = (in_byte == CH_SPACE) || (in_byte == CH_HYPHEN) ||
               (in_byte == CH_UNDERSCORE);

    emit = has_byte && (is_lower || is_upper || is_digit || (is_sep && !prev_was_underscore));
    if (is_upper) begin
      ch = in_byte + CASE_OFFSET;
    end else if (is_sep) begin
      ch = CH_UNDERSCORE;
    end else begin
      ch = in_byte;
    end

    hash_value_next          = has_byte ? fnv_step(hash_value, in_byte) : hash_value;
    saw_high_byte_next       = saw_high_byte || (has_byte && in_byte[7]);
    emitted_any_next         = emitted_any || emit;
    prev_was_underscore_next = emit ? is_sep : prev_was_underscore;

    job.ch_v     = emit;
    job.ch       = ch;
    job.tail     = name_end;
    job.untitled = !emitted_any_next;
    job.suffix   = saw_high_byte_next;
    job.hash     = hash_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_value          <= FNV_BASIS;
      saw_high_byte       <= 1'b0;
      emitted_any         <= 1'b0;
      prev_was_underscore <= 1'b0;
    end else if (advance) begin
      if (name_end) begin
        // start a fresh name
        hash_value          <= FNV_BASIS;
        saw_high_byte       <= 1'b0;
        emitted_any         <= 1'b0;
        prev_was_underscore <= 1'b0;
      end else begin
        hash_value          <= hash_value_next;
        saw_high_byte       <= saw_high_byte_next;
        emitted_any         <= emitted_any_next;
        prev_was_underscore <= prev_was_underscore_next;
      end
    end
  end

endmodule : nsfnv_name_state
`default_nettype wire

// File: src/nsfnv_tail_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsfnv_tail_seq
// Result register and sequencer: walks the results of one job, one per beat.
// ----------------------------------------------------------------------------
module nsfnv_tail_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire nsfnv_pkg::job_t job_in,
  output logic               free,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [15:0]        m_tdata,   // [7:0] out_char, [8] char_valid, [15:9] zero
  output logic               m_tlast    // out_last
);
  import nsfnv_pkg::*;

  job_t             job;
  logic             busy;
  logic [POS_W-1:0] pos, pos_next, first_pos, after_char;
  logic             is_last;
  logic [2:0]       sub;
  logic [7:0]       out_char;
  logic             char_valid;

  always_comb begin
    first_pos = job_in.ch_v ? POS_CHAR :
                job_in.untitled ? POS_UNT_0 :
                job_in.suffix ? POS_SEP : POS_END;
    after_char = job.untitled ? POS_UNT_0 : job.suffix ? POS_SEP : POS_END;
    if (pos == POS_CHAR) begin
      pos_next = after_char;
    end else if (pos == POS_UNT_LAST) begin
      pos_next = job.suffix ? POS_SEP : POS_END;
    end else begin
      pos_next = pos + 5'd1;
    end
    is_last = (pos == POS_END) || ((pos == POS_CHAR) && !job.tail);
    free    = !busy || (is_last && m_tready);
  end

  always_comb begin
    sub        = 3'd0;
    char_valid = 1'b1;
    if (pos == POS_CHAR) begin
      out_char = job.ch;
    end else if (pos <= POS_UNT_LAST) begin
      sub      = 3'(pos - POS_UNT_0);
      out_char = FALLBACK_NAME[(3'd7 - sub) * 8 +: 8];
    end else if (pos == POS_SEP) begin
      out_char = CH_UNDERSCORE;
    end else if (pos <= POS_HEX_LAST) begin
      // most significant nibble first
      sub      = 3'(POS_HEX_LAST - pos);
      out_char = hex_digit(job.hash[sub * 4 +: 4]);
    end else begin
      out_char   = CH_NUL;
      char_valid = 1'b0;
    end
    m_tvalid = busy;
    m_tdata  = {7'h0, char_valid, out_char};
    m_tlast  = (pos == POS_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_CHAR;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= first_pos;
    end else if (busy && m_tready) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

endmodule : nsfnv_tail_seq
`default_nettype wire
